FILE: design/dd_odom_pkg.sv
// Shared constants, state type and CORDIC table for the differential-drive odometry block.
// No dependencies; the interfaces and the top level take their widths from here.
`timescale 1ns / 1ps

package dd_odom_pkg;

   localparam int CORDIC_ITERS = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RADIUS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_HALF_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED       = 2'd2;

   localparam logic [15:0] RADIUS_RESET    = 16'd4162;
   localparam logic [15:0] HALF_BASE_RESET = 16'd13651;
   localparam logic [23:0] MAX_SPEED_RESET = 24'd6554;

   // arithmetic constants
   localparam logic [31:0] INV_PI_Q30   = 32'd341782638;
   localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // sequencer step counts
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] MUL_STEPS = 7'd32;
   localparam logic [CNT_W-1:0] DIV_STEPS = 7'd64;
   localparam logic [CNT_W-1:0] COR_STEPS = CNT_W'(CORDIC_ITERS);

   // atan(2^-i) as a 2*pi = 2^32 binary angle
   localparam logic [29:0] ATAN_TAB [0:30] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LMUL,
      ST_RMUL,
      ST_CHECK,
      ST_TMUL,
      ST_TDIV,
      ST_QDIV,
      ST_AMUL,
      ST_ADIV,
      ST_VMUL,
      ST_VDIV,
      ST_COR1,
      ST_XMUL,
      ST_YMUL,
      ST_COR2,
      ST_OUT
   } state_type;

endpackage

FILE: design/dd_odom_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on dd_odom_pkg for the register port widths.
`timescale 1ns / 1ps

interface dd_odom_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_angle;
   logic signed [31:0] right_angle;
   logic [19:0]        dt_us;

   modport source (output valid, output left_angle, output right_angle, output dt_us,
                   input ready);
   modport sink   (input valid, input left_angle, input right_angle, input dt_us,
                   output ready);
endinterface

interface dd_odom_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   logic signed [24:0] lin_vel;
   logic signed [31:0] ang_vel;

   modport source (output valid, output pos_x, output pos_y, output heading,
                   output quat_z, output quat_w, output lin_vel, output ang_vel,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input heading,
                   input quat_z, input quat_w, input lin_vel, input ang_vel,
                   output ready);
endinterface

interface dd_odom_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dd_odom_pkg::CSR_IDX_W-1:0]   index;
   logic [dd_odom_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/diff_drive_odometry.sv
// Differential-drive wheel odometry: one sequencer over a shift-add multiplier,
// a restoring divider and a CORDIC rotator. Depends on dd_odom_pkg and dd_odom_if.
//
// Each request carries both absolute wheel angles and the elapsed time. The block takes one
// request at a time: req ready is high only while idle, and it drops until the result has been
// taken. A priming request (the first after reset) or a request with dt_us zero still runs the
// two wheel-distance multiplies and the check, and then finishes with no result. Any other
// request walks a fixed sequence of seven multiplies on the one-bit-per-cycle multiplier, four
// divides on the one-bit-per-cycle divider, the check and two CORDIC passes before the result
// is valid. Register writes are taken at any time but belong in idle periods.
`timescale 1ns / 1ps

module diff_drive_odometry (
   input  logic                clock,
   input  logic                reset,
   dd_odom_req_if.sink         req_chan,
   dd_odom_rsp_if.source       rsp_chan,
   dd_odom_csr_if.sink         csr_chan
);

   // ---------------------------------------------------------------- helpers
   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      abs64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [19:0] s;
      t = 35'(v) + 35'sd16384;
      s = 20'(t >>> 15);
      if (s > 20'sd32767)
         to_q15 = 16'sh7fff;
      else if (s < -20'sd32768)
         to_q15 = 16'sh8000;
      else
         to_q15 = s[15:0];
   endfunction

   // ---------------------------------------------------------------- control state
   dd_odom_pkg::state_type state_ff, state_in;
   logic [dd_odom_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic primed_ff, primed_in;

   // configuration
   logic [15:0] radius_ff, radius_in;
   logic [15:0] half_base_ff, half_base_in;
   logic [23:0] max_speed_ff, max_speed_in;

   // odometry state
   logic signed [31:0] prev_l_ff, prev_l_in;
   logic signed [31:0] prev_r_ff, prev_r_in;
   logic signed [31:0] acc_x_ff, acc_x_in;
   logic signed [31:0] acc_y_ff, acc_y_in;
   logic [31:0]        acc_head_ff, acc_head_in;

   // request and intermediate values
   logic signed [31:0] left_ff, left_in;
   logic signed [31:0] right_ff, right_in;
   logic [19:0]        dt_ff, dt_in;
   logic signed [31:0] ldist_ff, ldist_in;
   logic signed [31:0] rdist_ff, rdist_in;
   logic signed [32:0] dc_ff, dc_in;
   logic signed [33:0] diff_ff, diff_in;
   logic [31:0]        turn_ff, turn_in;
   logic [42:0]        qmag_ff, qmag_in;
   logic               qneg_ff, qneg_in;
   logic               qsat_ff, qsat_in;

   // result registers
   logic signed [15:0] quat_z_ff, quat_z_in;
   logic signed [15:0] quat_w_ff, quat_w_in;
   logic signed [24:0] lin_ff, lin_in;
   logic signed [31:0] ang_ff, ang_in;

   // shared multiplier
   logic [63:0] mul_a_ff, mul_a_in;
   logic [31:0] mul_b_ff, mul_b_in;
   logic [63:0] mul_p_ff, mul_p_in;
   logic        mul_neg_ff, mul_neg_in;

   // shared divider (dividend shifts out as quotient shifts in)
   logic [63:0] div_n_ff, div_n_in;
   logic [19:0] div_r_ff, div_r_in;
   logic [19:0] div_d_ff, div_d_in;
   logic        div_neg_ff, div_neg_in;

   // shared CORDIC rotator
   logic signed [33:0] cor_x_ff, cor_x_in;
   logic signed [33:0] cor_y_ff, cor_y_in;
   logic signed [32:0] cor_z_ff, cor_z_in;
   logic               cor_flip_ff, cor_flip_in;

   // ---------------------------------------------------------------- datapath terms
   logic signed [64:0] prod_s;
   logic [20:0]        div_try;
   logic               div_ge;
   logic [20:0]        div_sub;
   logic [4:0]         cor_i;
   logic signed [33:0] cor_dx, cor_dy;
   logic signed [33:0] atan_s;
   logic signed [33:0] cor_xf, cor_yf;
   logic [15:0]        base_eff;
   logic [31:0]        cor_angle;
   logic [31:0]        cor_angle_p;
   logic signed [32:0] dl, dr;
   logic signed [33:0] dsum;
   logic signed [35:0] pos_sum;
   logic signed [34:0] pos_step;
   logic signed [31:0] pos_sat;
   logic [23:0]        lin_mag;
   logic [63:0]        diff_abs;
   logic [63:0]        cor_x_abs, cor_y_abs;
   logic               mul_go, div_go, cor_go;

   always_comb begin
      mul_go = cnt_ff != '0 && cnt_ff <= dd_odom_pkg::MUL_STEPS;
      div_go = cnt_ff != '0 && cnt_ff <= dd_odom_pkg::DIV_STEPS;
      cor_go = cnt_ff != '0 && cnt_ff <= dd_odom_pkg::COR_STEPS;

      prod_s   = mul_neg_ff ? -$signed({1'b0, mul_p_ff}) : $signed({1'b0, mul_p_ff});
      div_try  = {div_r_ff, div_n_ff[63]};
      div_ge   = div_try >= {1'b0, div_d_ff};
      div_sub  = div_ge ? div_try - {1'b0, div_d_ff} : div_try;
      cor_i    = 5'(cnt_ff - 7'd1);
      cor_dx   = cor_y_ff >>> cor_i;
      cor_dy   = cor_x_ff >>> cor_i;
      atan_s   = cor_go ? $signed({4'b0000, dd_odom_pkg::ATAN_TAB[cor_i]}) : 34'sd0;
      cor_xf   = cor_flip_ff ? -cor_x_ff : cor_x_ff;
      cor_yf   = cor_flip_ff ? -cor_y_ff : cor_y_ff;
      base_eff = (half_base_ff == 16'd0) ? 16'd1 : half_base_ff;
      dl       = 33'(ldist_ff) - 33'(prev_l_ff);
      dr       = 33'(rdist_ff) - 33'(prev_r_ff);
      dsum     = 34'(dl) + 34'(dr);
      diff_abs  = abs64(64'(diff_ff));
      cor_x_abs = abs64(64'(cor_x_ff));
      cor_y_abs = abs64(64'(cor_y_ff));
      pos_step = prod_s[64:30];
      pos_sum  = (state_ff == dd_odom_pkg::ST_XMUL) ? 36'(acc_x_ff) + 36'(pos_step)
                                                    : 36'(acc_y_ff) + 36'(pos_step);
      if (pos_sum > 36'sd2147483647)
         pos_sat = 32'sh7fffffff;
      else if (pos_sum < -36'sd2147483648)
         pos_sat = 32'sh80000000;
      else
         pos_sat = pos_sum[31:0];
      lin_mag  = (div_n_ff > {40'd0, max_speed_ff}) ? max_speed_ff : div_n_ff[23:0];
      // rotation angle for the CORDIC pass about to load
      cor_angle = (state_ff == dd_odom_pkg::ST_COR1) ? {acc_head_ff[30:0], 1'b0} + turn_ff
                                                     : acc_head_ff + turn_ff;
      cor_angle_p = cor_angle + 32'h4000_0000;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      primed_in    = primed_ff;
      radius_in    = radius_ff;
      half_base_in = half_base_ff;
      max_speed_in = max_speed_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_head_in  = acc_head_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      dt_in        = dt_ff;
      ldist_in     = ldist_ff;
      rdist_in     = rdist_ff;
      dc_in        = dc_ff;
      diff_in      = diff_ff;
      turn_in      = turn_ff;
      qmag_in      = qmag_ff;
      qneg_in      = qneg_ff;
      qsat_in      = qsat_ff;
      quat_z_in    = quat_z_ff;
      quat_w_in    = quat_w_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_p_in     = mul_p_ff;
      mul_neg_in   = mul_neg_ff;
      div_n_in     = div_n_ff;
      div_r_in     = div_r_ff;
      div_d_in     = div_d_ff;
      div_neg_in   = div_neg_ff;
      cor_x_in     = cor_x_ff;
      cor_y_in     = cor_y_ff;
      cor_z_in     = cor_z_ff;
      cor_flip_in  = cor_flip_ff;

      req_chan.ready = state_ff == dd_odom_pkg::ST_IDLE;
      rsp_chan.valid = state_ff == dd_odom_pkg::ST_OUT;
      csr_chan.ready = 1'b1;

      // register writes; an unknown index is ignored
      if (csr_chan.valid) begin
         case (csr_chan.index)
            dd_odom_pkg::CSR_WHEEL_RADIUS:    radius_in    = csr_chan.data[15:0];
            dd_odom_pkg::CSR_WHEEL_HALF_BASE: half_base_in = csr_chan.data[15:0];
            dd_odom_pkg::CSR_MAX_SPEED:       max_speed_in = csr_chan.data;
            default: ;
         endcase
      end

      // iterate whichever unit the current state owns
      if (state_ff inside {dd_odom_pkg::ST_LMUL, dd_odom_pkg::ST_RMUL, dd_odom_pkg::ST_TMUL,
                           dd_odom_pkg::ST_AMUL, dd_odom_pkg::ST_VMUL, dd_odom_pkg::ST_XMUL,
                           dd_odom_pkg::ST_YMUL} && mul_go) begin
         mul_p_in = mul_p_ff + (mul_b_ff[0] ? mul_a_ff : 64'd0);
         mul_a_in = {mul_a_ff[62:0], 1'b0};
         mul_b_in = {1'b0, mul_b_ff[31:1]};
      end
      if (state_ff inside {dd_odom_pkg::ST_TDIV, dd_odom_pkg::ST_QDIV, dd_odom_pkg::ST_ADIV,
                           dd_odom_pkg::ST_VDIV} && div_go) begin
         div_r_in = div_sub[19:0];
         div_n_in = {div_n_ff[62:0], div_ge};
      end
      if (state_ff inside {dd_odom_pkg::ST_COR1, dd_odom_pkg::ST_COR2} && cor_go) begin
         if (!cor_z_ff[32]) begin
            cor_x_in = cor_x_ff - cor_dx;
            cor_y_in = cor_y_ff + cor_dy;
            cor_z_in = cor_z_ff - 33'(atan_s);
         end else begin
            cor_x_in = cor_x_ff + cor_dx;
            cor_y_in = cor_y_ff - cor_dy;
            cor_z_in = cor_z_ff + 33'(atan_s);
         end
      end

      if (state_ff != dd_odom_pkg::ST_IDLE)
         cnt_in = cnt_ff + 7'd1;

      case (state_ff)
         dd_odom_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_chan.valid) begin
               left_in  = req_chan.left_angle;
               right_in = req_chan.right_angle;
               dt_in    = req_chan.dt_us;
               state_in = dd_odom_pkg::ST_LMUL;
            end
         end

         // wheel distances: floor(angle * radius / 2^16)
         dd_odom_pkg::ST_LMUL, dd_odom_pkg::ST_RMUL: begin
            if (cnt_ff == '0) begin
               mul_a_in   = abs64(64'(state_ff == dd_odom_pkg::ST_LMUL ? left_ff : right_ff));
               mul_b_in   = {16'd0, radius_ff};
               mul_p_in   = '0;
               mul_neg_in = (state_ff == dd_odom_pkg::ST_LMUL) ? left_ff[31] : right_ff[31];
            end else if (!mul_go) begin
               if (state_ff == dd_odom_pkg::ST_LMUL) begin
                  ldist_in = prod_s[47:16];
                  state_in = dd_odom_pkg::ST_RMUL;
               end else begin
                  rdist_in = prod_s[47:16];
                  state_in = dd_odom_pkg::ST_CHECK;
               end
               cnt_in = '0;
            end
         end

         // prime on the first request, drop zero elapsed time
         dd_odom_pkg::ST_CHECK: begin
            cnt_in = '0;
            if (!primed_ff) begin
               prev_l_in = ldist_ff;
               prev_r_in = rdist_ff;
               primed_in = 1'b1;
               state_in  = dd_odom_pkg::ST_IDLE;
            end else if (dt_ff == 20'd0) begin
               state_in = dd_odom_pkg::ST_IDLE;
            end else begin
               dc_in     = dsum[33:1];
               diff_in   = 34'(dr) - 34'(dl);
               prev_l_in = ldist_ff;
               prev_r_in = rdist_ff;
               state_in  = dd_odom_pkg::ST_TMUL;
            end
         end

         // turn = trunc(diff * (2^30/pi) / base)
         dd_odom_pkg::ST_TMUL: begin
            if (cnt_ff == '0) begin
               mul_a_in   = diff_abs;
               mul_b_in   = dd_odom_pkg::INV_PI_Q30;
               mul_p_in   = '0;
               mul_neg_in = diff_ff[33];
            end else if (!mul_go) begin
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_TDIV;
            end
         end

         dd_odom_pkg::ST_TDIV: begin
            if (cnt_ff == '0) begin
               div_n_in   = mul_p_ff;
               div_r_in   = '0;
               div_d_in   = {4'd0, base_eff};
               div_neg_in = mul_neg_ff;
            end else if (!div_go) begin
               turn_in  = div_neg_ff ? -div_n_ff[31:0] : div_n_ff[31:0];
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_QDIV;
            end
         end

         // q = trunc(diff * 2^16 / base), flag saturation
         dd_odom_pkg::ST_QDIV: begin
            if (cnt_ff == '0) begin
               div_n_in   = {diff_abs[47:0], 16'd0};
               div_r_in   = '0;
               div_d_in   = {4'd0, base_eff};
               div_neg_in = diff_ff[33];
            end else if (!div_go) begin
               qmag_in  = div_n_ff[42:0];
               qneg_in  = div_neg_ff;
               qsat_in  = div_n_ff[63:43] != '0;
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_AMUL;
            end
         end

         // angular velocity = trunc(q * 10^6 / dt), saturated
         dd_odom_pkg::ST_AMUL: begin
            if (cnt_ff == '0) begin
               mul_a_in   = {21'd0, qmag_ff};
               mul_b_in   = dd_odom_pkg::USEC_PER_SEC;
               mul_p_in   = '0;
               mul_neg_in = qneg_ff;
            end else if (!mul_go) begin
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_ADIV;
            end
         end

         dd_odom_pkg::ST_ADIV: begin
            if (cnt_ff == '0) begin
               div_n_in   = mul_p_ff;
               div_r_in   = '0;
               div_d_in   = dt_ff;
               div_neg_in = mul_neg_ff;
            end else if (!div_go) begin
               if (qsat_ff)
                  ang_in = qneg_ff ? 32'sh80000000 : 32'sh7fffffff;
               else if (div_neg_ff)
                  ang_in = (div_n_ff > 64'h8000_0000) ? 32'sh80000000 : -div_n_ff[31:0];
               else
                  ang_in = (div_n_ff > 64'h7fff_ffff) ? 32'sh7fffffff : div_n_ff[31:0];
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_VMUL;
            end
         end

         // linear velocity = trunc(dc * 10^6 / dt), clamped to max_speed
         dd_odom_pkg::ST_VMUL: begin
            if (cnt_ff == '0) begin
               mul_a_in   = abs64(64'(dc_ff));
               mul_b_in   = dd_odom_pkg::USEC_PER_SEC;
               mul_p_in   = '0;
               mul_neg_in = dc_ff[32];
            end else if (!mul_go) begin
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_VDIV;
            end
         end

         dd_odom_pkg::ST_VDIV: begin
            if (cnt_ff == '0) begin
               div_n_in   = mul_p_ff;
               div_r_in   = '0;
               div_d_in   = dt_ff;
               div_neg_in = mul_neg_ff;
            end else if (!div_go) begin
               lin_in   = div_neg_ff ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});
               cnt_in   = '0;
               state_in = dd_odom_pkg::ST_COR1;
            end
         end

         // sine and cosine of the mid-heading, then of the new heading
         dd_odom_pkg::ST_COR1, dd_odom_pkg::ST_COR2: begin
            if (cnt_ff == '0) begin
               // fold the left half-plane onto the right one
               cor_flip_in = cor_angle_p[31];
               cor_z_in    = $signed({~cor_angle_p[31] & cor_angle[31] |
                                      cor_angle_p[31] & ~cor_angle[31],
                                      (cor_angle_p[31] ? cor_angle ^ 32'h8000_0000
                                                       : cor_angle)});
               cor_x_in    = dd_odom_pkg::CORDIC_GAIN;
               cor_y_in    = '0;
               if (state_ff == dd_odom_pkg::ST_COR2)
                  acc_head_in = cor_angle;
            end else if (!cor_go) begin
               cor_x_in = cor_xf;
               cor_y_in = cor_yf;
               cnt_in   = '0;
               if (state_ff == dd_odom_pkg::ST_COR1) begin
                  state_in = dd_odom_pkg::ST_XMUL;
               end else begin
                  quat_z_in = to_q15(cor_yf);
                  quat_w_in = to_q15(cor_xf);
                  state_in  = dd_odom_pkg::ST_OUT;
               end
            end
         end

         // advance the position by floor(dc * cos / 2^30) and floor(dc * sin / 2^30)
         dd_odom_pkg::ST_XMUL, dd_odom_pkg::ST_YMUL: begin
            if (cnt_ff == '0) begin
               mul_a_in   = abs64(64'(dc_ff));
               mul_b_in   = (state_ff == dd_odom_pkg::ST_XMUL) ? cor_x_abs[31:0]
                                                               : cor_y_abs[31:0];
               mul_p_in   = '0;
               mul_neg_in = dc_ff[32] ^ ((state_ff == dd_odom_pkg::ST_XMUL) ? cor_x_ff[33]
                                                                            : cor_y_ff[33]);
            end else if (!mul_go) begin
               cnt_in = '0;
               if (state_ff == dd_odom_pkg::ST_XMUL) begin
                  acc_x_in = pos_sat;
                  state_in = dd_odom_pkg::ST_YMUL;
               end else begin
                  acc_y_in = pos_sat;
                  state_in = dd_odom_pkg::ST_COR2;
               end
            end
         end

         // hold the result until taken
         dd_odom_pkg::ST_OUT: begin
            cnt_in = '0;
            if (rsp_chan.ready)
               state_in = dd_odom_pkg::ST_IDLE;
         end

         default: begin
            cnt_in   = '0;
            state_in = dd_odom_pkg::ST_IDLE;
         end
      endcase
   end

   // result payload comes straight from the pose and result registers
   assign rsp_chan.pos_x   = acc_x_ff;
   assign rsp_chan.pos_y   = acc_y_ff;
   assign rsp_chan.heading = acc_head_ff;
   assign rsp_chan.quat_z  = quat_z_ff;
   assign rsp_chan.quat_w  = quat_w_ff;
   assign rsp_chan.lin_vel = lin_ff;
   assign rsp_chan.ang_vel = ang_ff;

   // ---------------------------------------------------------------- control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dd_odom_pkg::ST_IDLE;
         cnt_ff       <= '0;
         primed_ff    <= 1'b0;
         radius_ff    <= dd_odom_pkg::RADIUS_RESET;
         half_base_ff <= dd_odom_pkg::HALF_BASE_RESET;
         max_speed_ff <= dd_odom_pkg::MAX_SPEED_RESET;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_head_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         radius_ff    <= radius_in;
         half_base_ff <= half_base_in;
         max_speed_ff <= max_speed_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_head_ff  <= acc_head_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      dt_ff       <= dt_in;
      ldist_ff    <= ldist_in;
      rdist_ff    <= rdist_in;
      dc_ff       <= dc_in;
      diff_ff     <= diff_in;
      turn_ff     <= turn_in;
      qmag_ff     <= qmag_in;
      qneg_ff     <= qneg_in;
      qsat_ff     <= qsat_in;
      quat_z_ff   <= quat_z_in;
      quat_w_ff   <= quat_w_in;
      lin_ff      <= lin_in;
      ang_ff      <= ang_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_p_ff    <= mul_p_in;
      mul_neg_ff  <= mul_neg_in;
      div_n_ff    <= div_n_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      div_neg_ff  <= div_neg_in;
      cor_x_ff    <= cor_x_in;
      cor_y_ff    <= cor_y_in;
      cor_z_ff    <= cor_z_in;
      cor_flip_ff <= cor_flip_in;
   end

endmodule
